>>> rtl/core/fircb_pkg.sv
// ----------------------------------------------------------------------------
// fircb_pkg
// shared sizes, types and the coefficient table of the circular-buffer fir
// ----------------------------------------------------------------------------
package fircb_pkg;

	localparam int TAPS        = 33;
	localparam int SAMPLE_BITS = 16;
	localparam int ROM_DEPTH   = 33;
	localparam int COEF_W      = 8;
	localparam int ACC_W       = 32;
	localparam int DISP_W      = 8;
	localparam int DISP_SHIFT  = 13;
	localparam int ADDR_W      = $clog2(TAPS);
	localparam int PROD_W      = SAMPLE_BITS + COEF_W;

	localparam logic [DISP_W-1:0] DISP_BIAS = DISP_W'(128);

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t coef_rom_t [ROM_DEPTH];
	typedef coef_t coef_tab_t [TAPS];

	// coefficient table
	localparam coef_rom_t COEF_ROM = '{
		-8'sd1,  8'sd1,   8'sd58, -8'sd3,  -8'sd1,  8'sd13,  8'sd18, -8'sd1,
		 8'sd2, -8'sd28, -8'sd3,  -8'sd1,  -8'sd1, -8'sd75, -8'sd1,  -8'sd1,
		 8'sd5, -8'sd1,   8'sd1,   8'sd2,   8'sd1, -8'sd3,  -8'sd1,   8'sd1,
		-8'sd24, 8'sd1,  -8'sd1,   8'sd17, -8'sd1,  8'sd1,   8'sd1,   8'sd40,
		 8'sd4
	};

	// taps past the stored table get a zero coefficient
	function automatic coef_tab_t make_coef_tab();
		coef_tab_t t;
		for (int j = 0; j < TAPS; j++) begin
			t[j] = (j < ROM_DEPTH) ? COEF_ROM[j] : '0;
		end
		return t;
	endfunction

	localparam coef_tab_t COEF_TAB = make_coef_tab();

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic  clr;
		logic  en;
		logic  dvalid;
		coef_t coef;
	} mac_ctl_t;

endpackage

>>> rtl/core/fircb_if.sv
// ----------------------------------------------------------------------------
// fircb_if
// valid/ready channels for samples in and filter results out
// ----------------------------------------------------------------------------
interface fircb_sample_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [fircb_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface fircb_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [fircb_pkg::ACC_W-1:0] filtered;
	logic        [fircb_pkg::DISP_W-1:0] display_byte;

	modport source (output valid, output filtered, output display_byte, input ready);
	modport sink   (input valid, input filtered, input display_byte, output ready);
endinterface

>>> rtl/core/fircb_ram.sv
// ----------------------------------------------------------------------------
// fircb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fircb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/fircb_mac.sv
// ----------------------------------------------------------------------------
// fircb_mac
// shared multiply-accumulate unit, one tap per cycle while enabled, wraps at 32 bits
// ----------------------------------------------------------------------------
module fircb_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  fircb_pkg::mac_ctl_t                     ctl,
	input  logic signed [fircb_pkg::SAMPLE_BITS-1:0] data,
	output logic signed [fircb_pkg::ACC_W-1:0]       acc
);

	logic signed [fircb_pkg::PROD_W-1:0] prod;
	logic signed [fircb_pkg::ACC_W-1:0]  acc_q;

	assign prod = data * ctl.coef;
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.en && ctl.dvalid) begin
			acc_q <= acc_q + fircb_pkg::ACC_W'(prod);
		end
	end

endmodule

>>> rtl/core/fircb_ctrl.sv
// ----------------------------------------------------------------------------
// fircb_ctrl
// tap sequencer, delay-line pointers, entry valid bits and result register
// ----------------------------------------------------------------------------
module fircb_ctrl (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// sample side
	input  logic                                     in_valid,
	output logic                                     in_ready,
	// delay-line ram
	output logic                                     wr_en,
	output logic [fircb_pkg::ADDR_W-1:0]             wr_addr,
	output logic                                     rd_en,
	output logic [fircb_pkg::ADDR_W-1:0]             rd_addr,
	// mac
	output fircb_pkg::mac_ctl_t                      mac_ctl,
	input  logic signed [fircb_pkg::ACC_W-1:0]       acc,
	// result side
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [fircb_pkg::ACC_W-1:0]       filtered,
	output logic [fircb_pkg::DISP_W-1:0]             display_byte
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	localparam logic [fircb_pkg::ADDR_W-1:0] LAST = fircb_pkg::ADDR_W'(fircb_pkg::TAPS - 1);

	state_t                              state_q;
	logic [fircb_pkg::ADDR_W-1:0]        wo_q;
	logic [fircb_pkg::ADDR_W-1:0]        rd_ptr_q;
	logic [fircb_pkg::ADDR_W-1:0]        tap_q;
	logic                                entry_vld_q [fircb_pkg::TAPS];
	logic                                mac_en_s1;
	logic                                dvalid_s1;
	fircb_pkg::coef_t                    coef_s1;
	logic                                out_valid_q;
	logic signed [fircb_pkg::ACC_W-1:0]  filtered_q;
	logic [fircb_pkg::DISP_W-1:0]        disp_q;
	logic                                accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign wr_en   = accept;
	assign wr_addr = wo_q;
	assign rd_en   = (state_q == ST_RUN);
	assign rd_addr = rd_ptr_q;

	assign mac_ctl.clr    = accept;
	assign mac_ctl.en     = mac_en_s1;
	assign mac_ctl.dvalid = dvalid_s1;
	assign mac_ctl.coef   = coef_s1;

	assign out_valid    = out_valid_q;
	assign filtered     = filtered_q;
	assign display_byte = disp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wo_q        <= '0;
			rd_ptr_q    <= '0;
			tap_q       <= '0;
			mac_en_s1   <= 1'b0;
			dvalid_s1   <= 1'b0;
			coef_s1     <= '0;
			out_valid_q <= 1'b0;
			filtered_q  <= '0;
			disp_q      <= '0;
			for (int i = 0; i < fircb_pkg::TAPS; i++) begin
				entry_vld_q[i] <= 1'b0;
			end
		end else begin
			// the finish state handles the result register itself
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					mac_en_s1 <= 1'b0;
					if (accept) begin
						entry_vld_q[wo_q] <= 1'b1;
						rd_ptr_q          <= wo_q;
						tap_q             <= '0;
						state_q           <= ST_RUN;
					end
				end
				ST_RUN: begin
					mac_en_s1 <= 1'b1;
					dvalid_s1 <= entry_vld_q[rd_ptr_q];
					coef_s1   <= fircb_pkg::COEF_TAB[tap_q];
					rd_ptr_q  <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
					tap_q     <= tap_q + 1'b1;
					if (tap_q == LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					mac_en_s1 <= 1'b0;
					state_q   <= ST_FINISH;
				end
				ST_FINISH: begin
					mac_en_s1 <= 1'b0;
					if (!out_valid_q || out_ready) begin
						filtered_q  <= acc;
						disp_q      <= acc[fircb_pkg::DISP_SHIFT +: fircb_pkg::DISP_W]
							+ fircb_pkg::DISP_BIAS;
						out_valid_q <= 1'b1;
						wo_q        <= (wo_q == '0) ? LAST : wo_q - 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					mac_en_s1 <= 1'b0;
					state_q   <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/fir_filter_circular_buffer.sv
// ----------------------------------------------------------------------------
// fir_filter_circular_buffer
// 33-tap direct-form fir on a circular delay line with one shared mac
// a new sample is accepted only in the idle state; the single mac then walks all
// 33 taps through the delay-line ram read port, a drain state follows, and the
// finish state registers the result, waiting while the result channel stalls
// reset: arst_n clears the entry valid bits (delay line reads as zeros),
// the write offset and the result valid; no clearing pass is needed
// ----------------------------------------------------------------------------
module fir_filter_circular_buffer (
	input  logic                  clk,
	input  logic                  arst_n,
	fircb_sample_if.sink          sample_ch,
	fircb_result_if.source        result_ch
);

	// delay-line ram port signals
	logic                                     wr_en;
	logic [fircb_pkg::ADDR_W-1:0]             wr_addr;
	logic                                     rd_en;
	logic [fircb_pkg::ADDR_W-1:0]             rd_addr;
	logic [fircb_pkg::SAMPLE_BITS-1:0]        rd_data;

	// accumulator and its control
	fircb_pkg::mac_ctl_t                      mac_ctl;
	logic signed [fircb_pkg::ACC_W-1:0]       acc;

	// sequencer: takes the sample transaction, writes it at the write offset,
	// then walks the taps from the newest sample back and registers the result
	fircb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (sample_ch.valid),
		.in_ready     (sample_ch.ready),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.mac_ctl      (mac_ctl),
		.acc          (acc),
		.out_valid    (result_ch.valid),
		.out_ready    (result_ch.ready),
		.filtered     (result_ch.filtered),
		.display_byte (result_ch.display_byte)
	);

	// circular delay line, one entry per tap
	fircb_ram #(
		.WIDTH (fircb_pkg::SAMPLE_BITS),
		.DEPTH (fircb_pkg::TAPS)
	) u_delay (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (sample_ch.sample),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared multiply-accumulate, fed one tap per cycle from the ram
	fircb_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.data   (signed'(rd_data)),
		.acc    (acc)
	);

endmodule

>>> rtl/core/fircb_checker.sv
// ----------------------------------------------------------------------------
// fircb_checker
// port-level checks of the fir, bound to the top level
// ----------------------------------------------------------------------------
module fircb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [fircb_pkg::ACC_W-1:0]  filtered,
	input logic [fircb_pkg::DISP_W-1:0]        display_byte
);

	// display byte follows the filtered value whenever the result is valid
	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> display_byte ==
			filtered[fircb_pkg::DISP_SHIFT +: fircb_pkg::DISP_W] + fircb_pkg::DISP_BIAS)
		else $error("display byte does not match filtered");

	// sequencer goes busy right after a sample transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready after sample transaction");

	// still busy while the taps are being walked
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##(fircb_pkg::TAPS) !in_ready)
		else $error("ready before all taps done");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(filtered)))
		else $error("stalled result changed");

endmodule

bind fir_filter_circular_buffer fircb_checker u_fircb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample_ch.valid),
	.in_ready     (sample_ch.ready),
	.out_valid    (result_ch.valid),
	.out_ready    (result_ch.ready),
	.filtered     (result_ch.filtered),
	.display_byte (result_ch.display_byte)
);
